FILE: src/ecs_pkg.sv
// Shared types, opcodes and constants for the eight-bit CPU execute step.
// Used by the front decoder, the instruction queue and the execute back end.
package ecs_pkg;

  localparam int INSTR_BYTES = 4;
  localparam logic [15:0] PC_STEP = 16'(INSTR_BYTES);
  localparam logic [15:0] PC_HALT_MARK = 16'hFFFF;

  localparam int IN_BITS = 42;
  localparam int IN_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 77;
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW = $clog2(Q_DEPTH + 1);

  typedef enum logic [5:0] {
    OP_NOP  = 6'd0,  OP_MOV  = 6'd1,  OP_LOD  = 6'd2,  OP_OUT  = 6'd3,
    OP_INP  = 6'd4,  OP_JNZA = 6'd5,  OP_ADD  = 6'd6,  OP_ADDI = 6'd7,
    OP_SUB  = 6'd8,  OP_SUBI = 6'd9,  OP_NAD  = 6'd10, OP_NADI = 6'd11,
    OP_NOR  = 6'd12, OP_NORI = 6'd13, OP_CMP  = 6'd14, OP_CMPI = 6'd15,
    OP_JZRA = 6'd16, OP_LDRA = 6'd17, OP_WTRA = 6'd18, OP_JMPA = 6'd19,
    OP_JEQA = 6'd20, OP_JNQA = 6'd21, OP_JNZB = 6'd22, OP_JZRB = 6'd23,
    OP_JMPB = 6'd24, OP_JEQB = 6'd25, OP_JNQB = 6'd26, OP_LDRB = 6'd27,
    OP_WTRB = 6'd28, OP_JMPI = 6'd29, OP_JEQI = 6'd30, OP_JNQI = 6'd31,
    OP_JZRI = 6'd32, OP_JNZI = 6'd33
  } op_t;

  typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_NAND, ALU_NOR} alu_op_t;
  typedef enum logic [2:0] {WB_NONE, WB_REG, WB_IMM, WB_READ, WB_ALU} wb_src_t;
  typedef enum logic [2:0] {
    COND_NEVER, COND_ALWAYS, COND_Z, COND_NZ, COND_EQ, COND_NQ
  } cond_t;
  typedef enum logic [1:0] {TGT_A, TGT_B, TGT_IMM} tgt_t;

  typedef struct packed {
    logic        illegal;
    wb_src_t     wb_src;
    alu_op_t     alu_op;
    logic        use_imm;
    logic        is_cmp;
    logic        wr_en;
    logic        wr_io;
    logic        wr_ptr_b;
    cond_t       cond;
    tgt_t        tgt;
    logic [1:0]  dest;
    logic [1:0]  src;
    logic [7:0]  imm_byte;
    logic [15:0] imm_word;
    logic [7:0]  read_data;
  } dec_t;

  function automatic logic [7:0] pick4(input logic [1:0] sel, input logic [7:0] v0,
                                       input logic [7:0] v1, input logic [7:0] v2,
                                       input logic [7:0] v3);
    logic [7:0] r;
    case (sel)
      2'd0:    r = v0;
      2'd1:    r = v1;
      2'd2:    r = v2;
      default: r = v3;
    endcase
    return r;
  endfunction

endpackage

FILE: src/eight_bit_cpu_execute_step.sv
// Eight-bit CPU execute step: an accepted instruction transaction passes through the
// decoded-instruction queue and then the execute stage's result register before its
// result reaches the master side; throughput is one instruction per cycle while the
// master side accepts results. A two-entry decoded-instruction queue lets input keep
// flowing while a result waits. Synchronous reset clears registers, PC, flags, the queue and the output valid.
module eight_bit_cpu_execute_step import ecs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // func[5:0], dest_reg[7:6], src_reg[9:8], imm_byte[17:10], imm_word[33:18],
  // read_data[41:34], zero fill above
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // next_pc[15:0], pointer_a[31:16], pointer_b[47:32], write_valid[48],
  // write_space[49], write_address[65:50], write_data[73:66], flag_zero[74],
  // flag_equal[75], halted[76], zero fill above
  output logic [OUT_W-1:0] m_axis_tdata
);

  dec_t            dec, q_item;
  logic            push, q_full, q_valid, pop, halt_state;
  logic [Q_CW-1:0] q_count;

  ecs_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .push          (push),
    .dec           (dec)
  );

  ecs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (dec),
    .full  (q_full),
    .pop   (pop),
    .valid (q_valid),
    .dout  (q_item),
    .count (q_count)
  );

  ecs_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .item          (q_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .halt_state    (halt_state)
  );

`ifndef SYNTHESIS
  // Halt is sticky until reset.
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_state |=> halt_state)
    else $error("halt flag cleared without reset");

  // A result without a write reports zero write fields.
  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tdata[48]) |-> (m_axis_tdata[73:49] == '0))
    else $error("write fields nonzero on a result without a write");

  // The queue never holds more entries than its depth.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= Q_CW'(Q_DEPTH))
    else $error("instruction queue overflow");

  // A result is only produced from a queued instruction.
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(q_valid))
    else $error("result produced without a queued instruction");
`endif

endmodule

FILE: src/ecs_front.sv
// Front end: takes instruction transactions and decodes them into control words.
// Depends on ecs_pkg.
module ecs_front import ecs_pkg::*; (
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  // func[5:0], dest_reg[7:6], src_reg[9:8], imm_byte[17:10], imm_word[33:18],
  // read_data[41:34], zero fill above
  input  logic [IN_W-1:0] s_axis_tdata,
  input  logic            q_full,
  output logic            push,
  output dec_t            dec
);

  logic [5:0] func;

  assign func = s_axis_tdata[5:0];
  assign s_axis_tready = !q_full;
  assign push = s_axis_tvalid && !q_full;

  always_comb begin
    dec = '0;
    dec.wb_src    = WB_NONE;
    dec.alu_op    = ALU_ADD;
    dec.cond      = COND_NEVER;
    dec.tgt       = TGT_A;
    dec.dest      = s_axis_tdata[7:6];
    dec.src       = s_axis_tdata[9:8];
    dec.imm_byte  = s_axis_tdata[17:10];
    dec.imm_word  = s_axis_tdata[33:18];
    dec.read_data = s_axis_tdata[41:34];
    unique case (op_t'(func))
      OP_NOP: ;
      OP_MOV: dec.wb_src = WB_REG;
      OP_LOD: dec.wb_src = WB_IMM;
      OP_OUT: begin
        dec.wr_en = 1'b1;
        dec.wr_io = 1'b1;
      end
      OP_INP, OP_LDRA, OP_LDRB: dec.wb_src = WB_READ;
      OP_ADD, OP_ADDI: begin
        dec.wb_src  = WB_ALU;
        dec.alu_op  = ALU_ADD;
        dec.use_imm = (op_t'(func) == OP_ADDI);
      end
      OP_SUB, OP_SUBI: begin
        dec.wb_src  = WB_ALU;
        dec.alu_op  = ALU_SUB;
        dec.use_imm = (op_t'(func) == OP_SUBI);
      end
      OP_NAD, OP_NADI: begin
        dec.wb_src  = WB_ALU;
        dec.alu_op  = ALU_NAND;
        dec.use_imm = (op_t'(func) == OP_NADI);
      end
      OP_NOR, OP_NORI: begin
        dec.wb_src  = WB_ALU;
        dec.alu_op  = ALU_NOR;
        dec.use_imm = (op_t'(func) == OP_NORI);
      end
      OP_CMP, OP_CMPI: begin
        dec.is_cmp  = 1'b1;
        dec.use_imm = (op_t'(func) == OP_CMPI);
      end
      OP_WTRA: dec.wr_en = 1'b1;
      OP_WTRB: begin
        dec.wr_en    = 1'b1;
        dec.wr_ptr_b = 1'b1;
      end
      OP_JNZA: dec.cond = COND_NZ;
      OP_JZRA: dec.cond = COND_Z;
      OP_JMPA: dec.cond = COND_ALWAYS;
      OP_JEQA: dec.cond = COND_EQ;
      OP_JNQA: dec.cond = COND_NQ;
      OP_JNZB: begin
        dec.cond = COND_NZ;
        dec.tgt  = TGT_B;
      end
      OP_JZRB: begin
        dec.cond = COND_Z;
        dec.tgt  = TGT_B;
      end
      OP_JMPB: begin
        dec.cond = COND_ALWAYS;
        dec.tgt  = TGT_B;
      end
      OP_JEQB: begin
        dec.cond = COND_EQ;
        dec.tgt  = TGT_B;
      end
      OP_JNQB: begin
        dec.cond = COND_NQ;
        dec.tgt  = TGT_B;
      end
      OP_JMPI: begin
        dec.cond = COND_ALWAYS;
        dec.tgt  = TGT_IMM;
      end
      OP_JEQI: begin
        dec.cond = COND_EQ;
        dec.tgt  = TGT_IMM;
      end
      OP_JNQI: begin
        dec.cond = COND_NQ;
        dec.tgt  = TGT_IMM;
      end
      OP_JZRI: begin
        dec.cond = COND_Z;
        dec.tgt  = TGT_IMM;
      end
      OP_JNZI: begin
        dec.cond = COND_NZ;
        dec.tgt  = TGT_IMM;
      end
      default: dec.illegal = 1'b1;
    endcase
  end

endmodule

FILE: src/ecs_queue.sv
// Short first-word-fall-through queue of decoded instructions.
// Depends on ecs_pkg for the entry type and depth.
module ecs_queue import ecs_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dec_t            din,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output dec_t            dout,
  output logic [Q_CW-1:0] count
);

  dec_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;

  assign full  = (count == Q_CW'(Q_DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + Q_CW'(push) - Q_CW'(pop);
    end
  end

endmodule

FILE: src/ecs_back.sv
// Execute back end: register file, program counter, flags and result register.
// Depends on ecs_pkg.
module ecs_back import ecs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  dec_t             item,
  output logic             pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // next_pc[15:0], pointer_a[31:16], pointer_b[47:32], write_valid[48],
  // write_space[49], write_address[65:50], write_data[73:66], flag_zero[74],
  // flag_equal[75], halted[76], zero fill above
  output logic [OUT_W-1:0] m_axis_tdata,
  output logic             halt_state
);

  logic [7:0]  r0, r1, r2, r3;
  logic [15:0] pc;
  logic        zf, ef, hf;

  logic [7:0]  r0_next, r1_next, r2_next, r3_next;
  logic [15:0] pc_next;
  logic        zf_next, ef_next, hf_next;
  logic        wv, wsp;
  logic [15:0] waddr;
  logic [7:0]  wdata;

  logic [7:0]  opa, opb, opr, alu_res, wb_val;
  logic [15:0] pa, pb, target;
  logic        jump, we;

  assign pop = q_valid && (!m_axis_tvalid || m_axis_tready);
  assign halt_state = hf;

  assign pa  = {r1, r0};
  assign pb  = {r3, r2};
  assign opa = pick4(item.dest, r0, r1, r2, r3);
  assign opb = pick4(item.src, r0, r1, r2, r3);
  assign opr = item.use_imm ? item.imm_byte : opb;

  always_comb begin
    case (item.alu_op)
      ALU_ADD:  alu_res = opa + opr;
      ALU_SUB:  alu_res = opa - opr;
      ALU_NAND: alu_res = ~(opa & opr);
      default:  alu_res = ~(opa | opr);
    endcase
  end

  always_comb begin
    we = 1'b1;
    case (item.wb_src)
      WB_REG:  wb_val = opb;
      WB_IMM:  wb_val = item.imm_byte;
      WB_READ: wb_val = item.read_data;
      WB_ALU:  wb_val = alu_res;
      default: begin
        wb_val = '0;
        we     = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (item.cond)
      COND_ALWAYS: jump = 1'b1;
      COND_Z:      jump = zf;
      COND_NZ:     jump = !zf;
      COND_EQ:     jump = ef;
      COND_NQ:     jump = !ef;
      default:     jump = 1'b0;
    endcase
    case (item.tgt)
      TGT_B:   target = pb;
      TGT_IMM: target = item.imm_word;
      default: target = pa;
    endcase
  end

  always_comb begin
    r0_next = r0;
    r1_next = r1;
    r2_next = r2;
    r3_next = r3;
    pc_next = pc;
    zf_next = zf;
    ef_next = ef;
    hf_next = hf;
    wv      = 1'b0;
    wsp     = 1'b0;
    waddr   = '0;
    wdata   = '0;
    if (!hf) begin
      if (we) begin
        case (item.dest)
          2'd0:    r0_next = wb_val;
          2'd1:    r1_next = wb_val;
          2'd2:    r2_next = wb_val;
          default: r3_next = wb_val;
        endcase
      end
      if (item.is_cmp) begin
        ef_next = (opa == opr);
        zf_next = (opa == '0);
      end
      if (item.wr_en) begin
        wv    = 1'b1;
        wsp   = item.wr_io;
        waddr = item.wr_ptr_b ? pb : pa;
        wdata = opa;
      end
      pc_next = jump ? target : pc + PC_STEP;
      hf_next = item.illegal || (pc_next == PC_HALT_MARK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r0 <= '0;
      r1 <= '0;
      r2 <= '0;
      r3 <= '0;
      pc <= '0;
      zf <= 1'b0;
      ef <= 1'b0;
      hf <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (pop) begin
      r0 <= r0_next;
      r1 <= r1_next;
      r2 <= r2_next;
      r3 <= r3_next;
      pc <= pc_next;
      zf <= zf_next;
      ef <= ef_next;
      hf <= hf_next;
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // The result word carries no reset; it is only looked at while tvalid is high.
  always_ff @(posedge clk) begin
    if (pop) begin
      m_axis_tdata <= {(OUT_W - OUT_BITS)'(0), hf_next, ef_next, zf_next, wdata, waddr,
                       wsp, wv, r3_next, r2_next, r1_next, r0_next, pc_next};
    end
  end

endmodule
